[rtl/pls_pkg.sv]
// Shared types, codes and field widths for the packed list store.
package pls_pkg;

    localparam int OP_W     = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 6;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 6;
    localparam int COUNT_W  = 7;

    localparam logic [OP_W-1:0] OP_APPEND    = 3'd0;
    localparam logic [OP_W-1:0] OP_FIND      = 3'd1;
    localparam logic [OP_W-1:0] OP_READ      = 3'd2;
    localparam logic [OP_W-1:0] OP_RM_VALUE  = 3'd3;
    localparam logic [OP_W-1:0] OP_RM_INDEX  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOMATCH = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0]   position;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  result_index;
        logic [VALUE_W-1:0]  result_value;
        logic [COUNT_W-1:0]  entry_count;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                accept;
        logic                append;
        logic                set_status;
        logic [STATUS_W-1:0] status;
        logic                start_search;
        logic                start_read;
        logic                rd;
        logic                capture;
        logic                shift;
        logic                clear_last;
        logic                load_out;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            empty;
        logic            full;
        logic            ptr_ok;
        logic            rd_vld;
        logic            hit;
        logic            at_last;
        logic            out_free;
    } t_dp_stat;

endpackage

[rtl/pls_chan_if.sv]
// Valid/ready channel carrying one payload beat of type T.
interface pls_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/pls_ctrl.sv]
// Controller state machine sequencing append, search, read, shift and response.
module pls_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  pls_pkg::t_dp_stat i_stat,
    output pls_pkg::t_dp_cmd  o_cmd
);
    import pls_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_DISPATCH = 8'b0000_0010,
        S_SEARCH   = 8'b0000_0100,
        S_RD_ISSUE = 8'b0000_1000,
        S_RD_WAIT  = 8'b0001_0000,
        S_SHIFT    = 8'b0010_0000,
        S_CLEAR    = 8'b0100_0000,
        S_FINISH   = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_cmd      = '0;
        n_state    = r_state;
        o_in_ready = (r_state == S_IDLE) && i_rst_n;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                priority if (i_stat.op == OP_APPEND) begin
                    if (i_stat.full) begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = ST_FULL;
                    end else begin
                        o_cmd.append = 1'b1;
                    end
                    n_state = S_FINISH;
                end else if (i_stat.op == OP_FIND || i_stat.op == OP_RM_VALUE) begin
                    if (i_stat.empty) begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = ST_EMPTY;
                        n_state          = S_FINISH;
                    end else begin
                        o_cmd.start_search = 1'b1;
                        n_state            = S_SEARCH;
                    end
                end else if (i_stat.op == OP_READ || i_stat.op == OP_RM_INDEX) begin
                    if (i_stat.empty) begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = ST_EMPTY;
                        n_state          = S_FINISH;
                    end else begin
                        o_cmd.start_read = 1'b1;
                        n_state          = S_RD_ISSUE;
                    end
                end else begin
                    // Unused operation codes leave the list alone and report ok.
                    n_state = S_FINISH;
                end
            end
            S_SEARCH: begin
                // Reads are pipelined one deep, so results come back in index order.
                priority if (i_stat.rd_vld && i_stat.hit) begin
                    o_cmd.capture = 1'b1;
                    n_state       = (i_stat.op == OP_FIND) ? S_FINISH : S_SHIFT;
                end else if (i_stat.rd_vld && i_stat.at_last) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_NOMATCH;
                    n_state          = S_FINISH;
                end else begin
                    o_cmd.rd = 1'b1;
                end
            end
            S_RD_ISSUE: begin
                o_cmd.rd = 1'b1;
                n_state  = S_RD_WAIT;
            end
            S_RD_WAIT: begin
                o_cmd.capture = 1'b1;
                n_state       = (i_stat.op == OP_RM_INDEX) ? S_SHIFT : S_FINISH;
            end
            S_SHIFT: begin
                o_cmd.rd    = 1'b1;
                o_cmd.shift = 1'b1;
                if (!i_stat.ptr_ok && !i_stat.rd_vld) begin
                    n_state = S_CLEAR;
                end
            end
            S_CLEAR: begin
                o_cmd.clear_last = 1'b1;
                n_state          = S_FINISH;
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/pls_dp.sv]
// Datapath: entry memory, count, walk pointer, compare and response register.
module pls_dp #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pls_pkg::t_in_item  i_item,
    input  pls_pkg::t_dp_cmd   i_cmd,
    output pls_pkg::t_dp_stat  o_stat,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output pls_pkg::t_out_item o_out_item
);
    import pls_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    logic [OP_W-1:0]       r_op;
    logic [DATA_WIDTH-1:0] r_value;
    logic [POS_W-1:0]      r_pos;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         r_ptr;
    logic [DATA_WIDTH-1:0] r_rd_data;
    logic [AW-1:0]         r_rd_tag;
    logic                  r_rd_vld;
    logic [STATUS_W-1:0]   r_res_status;
    logic [AW-1:0]         r_res_idx;
    logic [DATA_WIDTH-1:0] r_res_val;
    logic                  r_out_valid;
    t_out_item             r_out_item;

    logic [CW-1:0]         count_m1;
    logic [AW-1:0]         clamp_idx;
    logic                  rd_fire;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;

    assign count_m1  = r_count - CW'(1);
    assign clamp_idx = (PW'(r_pos) >= PW'(r_count)) ? AW'(count_m1) : AW'(r_pos);
    assign rd_fire   = i_cmd.rd && (r_ptr < r_count);

    assign o_stat.op       = r_op;
    assign o_stat.empty    = (r_count == '0);
    assign o_stat.full     = (r_count == CW'(DEPTH));
    assign o_stat.ptr_ok   = (r_ptr < r_count);
    assign o_stat.rd_vld   = r_rd_vld;
    assign o_stat.hit      = (r_rd_data == r_value);
    assign o_stat.at_last  = (CW'(r_rd_tag) == count_m1);
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    // Single write port: append, move one entry down, or clear the vacated slot.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        priority if (i_cmd.append) begin
            wr_en   = 1'b1;
            wr_addr = r_count[AW-1:0];
            wr_data = r_value;
        end else if (i_cmd.shift && r_rd_vld) begin
            wr_en   = 1'b1;
            wr_addr = r_rd_tag - AW'(1);
            wr_data = r_rd_data;
        end else if (i_cmd.clear_last) begin
            wr_en   = 1'b1;
            wr_addr = AW'(count_m1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_fire) begin
            r_rd_data <= mem[r_ptr[AW-1:0]];
            r_rd_tag  <= r_ptr[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op    <= i_item.operation;
            r_value <= DATA_WIDTH'(i_item.value);
            r_pos   <= i_item.position;
        end

        priority if (i_cmd.accept) begin
            r_res_status <= ST_OK;
            r_res_idx    <= '0;
            r_res_val    <= '0;
        end else if (i_cmd.set_status) begin
            r_res_status <= i_cmd.status;
        end else if (i_cmd.append) begin
            r_res_idx <= r_count[AW-1:0];
        end else if (i_cmd.capture) begin
            r_res_idx <= r_rd_tag;
            r_res_val <= (r_op == OP_FIND) ? '0 : r_rd_data;
        end

        priority if (i_cmd.start_search) begin
            r_ptr <= '0;
        end else if (i_cmd.start_read) begin
            r_ptr <= CW'(clamp_idx);
        end else if (i_cmd.capture) begin
            // The shift starts with the entry just above the removed one.
            r_ptr <= CW'(r_rd_tag) + CW'(1);
        end else if (rd_fire) begin
            r_ptr <= r_ptr + CW'(1);
        end

        if (i_cmd.load_out) begin
            r_out_item.status       <= r_res_status;
            r_out_item.result_index <= INDEX_W'(r_res_idx);
            r_out_item.result_value <= VALUE_W'(r_res_val);
            r_out_item.entry_count  <= COUNT_W'(r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_vld <= rd_fire;
            priority if (i_cmd.append) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.clear_last) begin
                r_count <= count_m1;
            end
            priority if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

[rtl/packed_list_store_core.sv]
// Packed list store: one operation at a time, entries walked one per cycle through a memory.
// Append and the unused codes go from accept through dispatch to finish; read adds an
// issue and a wait state; find and the removals walk the list, as the memory read
// port visits one entry per cycle for the search and for the shift-down.
// A new beat is accepted in the cycle after the response is registered.
// Synchronous active-low reset empties the list; stale words above the count are never read.
module packed_list_store_core #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input logic        i_clk,
    input logic        i_rst_n,
    pls_chan_if.sink   i_req,
    pls_chan_if.source o_rsp
);
    import pls_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    pls_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    pls_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_req.data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_out_item  (o_rsp.data)
    );

endmodule

[rtl/pls_checker.sv]
// Port-level checks for the packed list store, bound to the top level.
module pls_checker #(
    parameter int DEPTH = 64
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input pls_pkg::t_out_item i_out_item
);
    import pls_pkg::*;

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_item))
        else $error("response beat dropped or changed while stalled");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second request accepted while one is in flight");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_item.status != ST_OK) |->
            (i_out_item.result_index == '0) && (i_out_item.result_value == '0))
        else $error("error response carries nonzero index or data");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_item.status == ST_FULL) |->
            i_out_item.entry_count == COUNT_W'(DEPTH))
        else $error("full status with count below capacity");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_item.status == ST_EMPTY) |->
            i_out_item.entry_count == '0)
        else $error("empty status with nonzero count");

endmodule

bind packed_list_store_core pls_checker #(
    .DEPTH (DEPTH)
) u_pls_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_out_item  (o_rsp.data)
);
